// ===== rtl/amc_pkg.sv =====
// Shared types, constants and the divide-by-255 helper for the alpha mask compositor.
// Used by every module of the block; depends on nothing else.
package amc_pkg;

   localparam int ALPHA_W     = 8;
   localparam int PROD_W      = 2 * ALPHA_W;
   localparam int CSR_INDEX_W = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ALPHA_W-1:0] ALPHA_MAX  = 8'd255;
   localparam logic [ALPHA_W-1:0] ALPHA_HALF = 8'd127;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPOSITE_MODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYER_OPACITY  = 8'd1;

   typedef enum logic [1:0] {
      MODE_OVER     = 2'd0,
      MODE_CLEAR    = 2'd1,
      MODE_ERASE    = 2'd2,
      MODE_SUBTRACT = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [ALPHA_W-1:0] opacity;
   } cfg_type;

   // One classified request. When blend is low, word[7:0] already holds the result.
   // When blend is high, word holds source times opacity and the back end finishes it.
   typedef struct packed {
      logic               blend;
      logic [ALPHA_W-1:0] dest;
      logic [PROD_W-1:0]  word;
   } entry_type;

   // Exact floor(x / 255) for every x below 65280, which covers all values used here.
   function automatic logic [ALPHA_W-1:0] div255(input logic [PROD_W:0] x);
      logic [PROD_W+1:0] sum;
      begin
         sum = {1'b0, x} + {{(ALPHA_W+1){1'b0}}, x[PROD_W:ALPHA_W]} + (PROD_W+2)'(1);
         div255 = sum[PROD_W-1:ALPHA_W];
      end
   endfunction

endpackage

// ===== rtl/amc_front.sv =====
// Front end of the alpha mask compositor: classifies each request by mode and opacity.
// Uses amc_pkg; feeds the request queue.
module amc_front (
   input  amc_pkg::cfg_type                 cfg,
   input  logic [amc_pkg::ALPHA_W-1:0]      dest_alpha,
   input  logic [amc_pkg::ALPHA_W-1:0]      source_alpha,
   output amc_pkg::entry_type               entry
);

   logic [amc_pkg::PROD_W-1:0] product;

   assign product = amc_pkg::PROD_W'(source_alpha) * amc_pkg::PROD_W'(cfg.opacity);

   always_comb begin
      entry.blend = 1'b0;
      entry.dest  = dest_alpha;
      entry.word  = '0;
      unique case (cfg.mode)
         amc_pkg::MODE_CLEAR: begin
            entry.word = '0;
         end
         amc_pkg::MODE_ERASE: begin
            entry.word = amc_pkg::PROD_W'((dest_alpha < source_alpha) ? dest_alpha
                                                                      : source_alpha);
         end
         amc_pkg::MODE_SUBTRACT: begin
            entry.word = (dest_alpha > source_alpha)
                         ? amc_pkg::PROD_W'(dest_alpha - source_alpha) : '0;
         end
         default: begin
            if ((cfg.opacity == '0) || (source_alpha == '0)) begin
               entry.word = amc_pkg::PROD_W'(dest_alpha);
            end else if ((cfg.opacity == amc_pkg::ALPHA_MAX) &&
                         ((dest_alpha == '0) || (source_alpha == amc_pkg::ALPHA_MAX))) begin
               entry.word = amc_pkg::PROD_W'(source_alpha);
            end else begin
               // At full opacity the scaled source rounds back to the source itself.
               entry.blend = 1'b1;
               entry.word  = product;
            end
         end
      endcase
   end

endmodule

// ===== rtl/amc_queue.sv =====
// Short request queue between the front and back ends of the alpha mask compositor.
// Uses amc_pkg for the entry type and depth.
module amc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  amc_pkg::entry_type  push_entry,
   output logic                full,
   output logic                not_empty,
   input  logic                pop,
   output amc_pkg::entry_type  pop_entry
);

   localparam int PW = amc_pkg::QUEUE_PTR_W;
   localparam int CW = amc_pkg::QUEUE_CNT_W;

   amc_pkg::entry_type entries_ff [amc_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff,  count_in;

   assign full      = (count_ff == CW'(amc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(amc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(amc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(amc_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> full)
      else $error("queue left full state without a pop");
`endif

endmodule

// ===== rtl/amc_back.sv =====
// Back end of the alpha mask compositor: finishes the over blend in two stages.
// Uses amc_pkg for the entry type and the divide-by-255 helper; drains the request queue.
module amc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          entry_ready,
   input  amc_pkg::entry_type            entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [amc_pkg::ALPHA_W-1:0]   rsp_result_alpha
);

   localparam int AW = amc_pkg::ALPHA_W;
   localparam int PW = amc_pkg::PROD_W;

   logic           advance;
   logic [AW-1:0]  scaled_alpha;
   logic [PW:0]    blend_sum;

   logic           st_valid_ff, st_valid_in;
   logic           st_blend_ff;
   logic [PW-1:0]  st_word_ff, st_word_in;
   logic           out_valid_ff, out_valid_in;
   logic [AW-1:0]  out_data_ff, out_data_in;

   // The whole back pipeline moves together unless the output is held.
   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && entry_ready;

   always_comb begin
      scaled_alpha = amc_pkg::div255((PW+1)'(entry.word) + (PW+1)'(amc_pkg::ALPHA_HALF));
      blend_sum = (PW+1)'(PW'(entry.dest) * PW'(amc_pkg::ALPHA_MAX - scaled_alpha))
                + (PW+1)'({scaled_alpha, {AW{1'b0}}})
                - (PW+1)'(scaled_alpha)
                + (PW+1)'(amc_pkg::ALPHA_HALF);
      st_word_in   = entry.blend ? blend_sum[PW-1:0] : entry.word;
      st_valid_in  = advance ? entry_ready : st_valid_ff;
      out_valid_in = advance ? st_valid_ff : out_valid_ff;
      out_data_in  = st_blend_ff ? amc_pkg::div255({1'b0, st_word_ff}) : st_word_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_valid_ff  <= st_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_blend_ff <= entry.blend;
         st_word_ff  <= st_word_in;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_alpha = out_data_ff;

`ifndef SYNTHESIS
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && st_valid_ff) |=> (st_valid_ff && $stable(st_word_ff)))
      else $error("blend stage lost its request while the output was held");

   a_pop_when_moving: assert property (@(posedge clock) disable iff (reset)
      pop |=> st_valid_ff)
      else $error("popped request did not reach the blend stage");
`endif

endmodule

// ===== rtl/alpha_mask_compositor_core.sv =====
// Top level of the alpha mask compositor: configuration registers and the three parts.
// Uses amc_pkg, amc_front, amc_queue and amc_back.
//
// This block takes one request per clock while req_stall is low, each a destination and a
// source 8-bit alpha value, and returns one composited destination alpha per request, in
// order. The mode (over, clear, erase, subtract) and the layer opacity come from two
// configuration registers written through the csr_ port, which is always ready and must
// only be written while no request is in flight. A request is accepted on a clock edge
// where req_valid is high and req_stall is low; it passes through the two-entry request
// queue that the front end writes and then the back end, which computes the scaled source
// and the blend product in one stage and the final divide by 255 into the output register
// in the next, and its result then appears on rsp_. The sustained rate is one request per
// clock while rsp_stall stays low. A result held by rsp_stall does not block acceptance
// until the queue behind it fills.
module alpha_mask_compositor_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [amc_pkg::ALPHA_W-1:0]       req_dest_alpha,
   input  logic [amc_pkg::ALPHA_W-1:0]       req_source_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [amc_pkg::ALPHA_W-1:0]       rsp_result_alpha,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [amc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [amc_pkg::ALPHA_W-1:0]       csr_data
);

   amc_pkg::cfg_type   cfg_ff, cfg_in;
   amc_pkg::entry_type front_entry;
   amc_pkg::entry_type queue_entry;
   logic               queue_full;
   logic               queue_not_empty;
   logic               queue_push;
   logic               queue_pop;

   // Configuration writes complete in the cycle they are presented.
   assign csr_ready = 1'b1;

   // Writes to an index beyond the two registers are dropped; a mode write keeps only the low two data bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == amc_pkg::CSR_COMPOSITE_MODE) begin
            cfg_in.mode = amc_pkg::mode_type'(csr_data[1:0]);
         end else if (csr_index == amc_pkg::CSR_LAYER_OPACITY) begin
            cfg_in.opacity = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= amc_pkg::MODE_OVER;
         cfg_ff.opacity <= amc_pkg::ALPHA_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end only stalls when the queue has no room left.
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   amc_front u_front (
      .cfg          (cfg_ff),
      .dest_alpha   (req_dest_alpha),
      .source_alpha (req_source_alpha),
      .entry        (front_entry)
   );

   amc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (front_entry),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .pop        (queue_pop),
      .pop_entry  (queue_entry)
   );

   amc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .entry_ready      (queue_not_empty),
      .entry            (queue_entry),
      .pop              (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_alpha (rsp_result_alpha)
   );

endmodule
